[sv/drpi_pkg.sv]
// drpi_pkg: shared constants, codes, state types and the arctangent table
// for the dead-reckoning pose integrator and its cordic unit
// depends on nothing
`timescale 1ns / 1ps

package drpi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int POS_W   = 48;
    localparam int ANG_W   = 32;
    localparam int MAG_W   = 32;
    localparam int TRIG_W  = 32;
    localparam int DIST_W  = 41;
    localparam int LO_W    = 21;
    localparam int HI_W    = DIST_W - LO_W;
    localparam int PROD_W  = 64;
    localparam int PLO_W   = LO_W + TRIG_W;
    localparam int PHI_W   = HI_W + TRIG_W;
    localparam int WIDE_W  = PHI_W + LO_W;
    localparam int RES_W   = WIDE_W - 30;
    localparam int INCR_W  = RES_W + 1;
    localparam int QA_W    = 26;
    localparam int REM_W   = 6;
    localparam int Q2_W    = 13;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [31:0] RECIP_100  = 32'd2748779070;
    localparam logic [31:0] RECIP_10   = 32'd3435973837;
    localparam logic [31:0] RECIP_45   = 32'd3054198967;
    localparam logic [31:0] RAD_TO_BAM = 32'd683565276;
    localparam logic [31:0] KM_SCALE   = 32'd1000;
    localparam logic [31:0] CM_BIAS    = 32'd50;
    localparam logic [31:0] DM_BIAS    = 32'd5;
    localparam logic [31:0] DEG_BIAS   = 32'd22;
    localparam int SHIFT_100 = 38;
    localparam int SHIFT_10  = 35;
    localparam int SHIFT_45  = 37;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [1:0] ACT_ADVANCE = 2'd0;
    localparam logic [1:0] ACT_TURN    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] UNIT_CM  = 2'd0;
    localparam logic [1:0] UNIT_DM  = 2'd1;
    localparam logic [1:0] UNIT_M   = 2'd2;
    localparam logic [1:0] UNIT_KM  = 2'd3;
    localparam logic [1:0] UNIT_RAD = 2'd1;

    localparam logic REG_START_X = 1'b0;
    localparam logic REG_START_Y = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADV_MUL,
        ST_ADV_DIST,
        ST_TRIG_WAIT,
        ST_MXL,
        ST_MXH,
        ST_MYL,
        ST_MYH,
        ST_SUMY,
        ST_ADDY,
        ST_TURN_MUL,
        ST_RAD_ADD,
        ST_DEG_Q,
        ST_DEG_R,
        ST_DEG_MUL,
        ST_DEG_ADD,
        ST_RESTART,
        ST_REPORT
    } pose_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_FINISH
    } cordic_state_t;

    typedef struct packed {
        logic [TRIG_W-1:0] cos_mag;
        logic              cos_neg;
        logic [TRIG_W-1:0] sin_mag;
        logic              sin_neg;
    } trig_t;

    function automatic logic [ANG_W-1:0] atan_bam(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[sv/drpi_cordic.sv]
// drpi_cordic: iterative cordic rotation, one shift-add step per cycle,
// gives cosine and sine of a binary angle as magnitude and sign in q30
// depends on drpi_pkg
`timescale 1ns / 1ps

module drpi_cordic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [drpi_pkg::ANG_W-1:0]  angle,
    output logic                        done,
    output drpi_pkg::trig_t             trig
);

    drpi_pkg::cordic_state_t state_reg;
    drpi_pkg::cordic_state_t state_next;

    logic [drpi_pkg::STEP_W-1:0]        cnt_reg;
    logic                               done_reg;
    logic                               flip_reg;
    logic signed [drpi_pkg::TRIG_W-1:0] x_reg;
    logic signed [drpi_pkg::TRIG_W-1:0] y_reg;
    logic signed [drpi_pkg::ANG_W-1:0]  z_reg;
    drpi_pkg::trig_t                    trig_reg;

    logic                               load;
    logic                               step;
    logic                               finish;
    logic                               last_step;
    logic                               flip;
    logic signed [drpi_pkg::TRIG_W-1:0] x_shift;
    logic signed [drpi_pkg::TRIG_W-1:0] y_shift;
    logic [drpi_pkg::ANG_W-1:0]         atan_val;

    assign last_step = (cnt_reg == drpi_pkg::STEP_W'(drpi_pkg::CORDIC_STEPS - 1));
    assign flip      = angle[31] ^ angle[30];
    assign x_shift   = x_reg >>> cnt_reg;
    assign y_shift   = y_reg >>> cnt_reg;
    assign atan_val  = drpi_pkg::atan_bam(5'(cnt_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drpi_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    state_next = drpi_pkg::CS_ITER;
                end
            end
            drpi_pkg::CS_ITER:
            begin
                if (last_step)
                begin
                    state_next = drpi_pkg::CS_FINISH;
                end
            end
            drpi_pkg::CS_FINISH:
            begin
                state_next = drpi_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = drpi_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load   = 1'b0;
        step   = 1'b0;
        finish = 1'b0;
        case (state_reg)
            drpi_pkg::CS_IDLE:   load   = start;
            drpi_pkg::CS_ITER:   step   = 1'b1;
            drpi_pkg::CS_FINISH: finish = 1'b1;
            default:             load   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drpi_pkg::CS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                cnt_reg  <= '0;
                done_reg <= 1'b0;
            end
            else if (step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (finish)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // fold into the right half plane, flip undone at the end
            x_reg    <= drpi_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({angle[31] ^ flip, angle[30:0]});
            flip_reg <= flip;
        end
        else if (step)
        begin
            if (!z_reg[31])
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - $signed(atan_val);
            end
            else
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + $signed(atan_val);
            end
        end
        else if (finish)
        begin
            trig_reg.cos_mag <= x_reg[31] ? 32'(-x_reg) : 32'(x_reg);
            trig_reg.cos_neg <= flip_reg ^ x_reg[31];
            trig_reg.sin_mag <= y_reg[31] ? 32'(-y_reg) : 32'(y_reg);
            trig_reg.sin_neg <= flip_reg ^ y_reg[31];
        end
    end

    assign done = done_reg;
    assign trig = trig_reg;

endmodule

[sv/dead_reckoning_pose_integrator.sv]
// dead_reckoning_pose_integrator: planar pose tracker for rover motion commands
// advance: one pass through the shared 32x32 multiplier converts the distance while the
// cordic iteration loop runs, then four more passes form the x and y products
// turn: multiply and add, with quotient and remainder steps for degrees; one item at a time
// a new input transfer is taken once the result sits in the output register
// reset clears pose, heading, overflow flag and start registers; no clearing pass
`timescale 1ns / 1ps

module dead_reckoning_pose_integrator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [drpi_pkg::POS_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic signed [drpi_pkg::MAG_W-1:0]   magnitude,
    input  logic [1:0]                          unit,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [drpi_pkg::POS_W-1:0]   pos_x,
    output logic signed [drpi_pkg::POS_W-1:0]   pos_y,
    output logic [drpi_pkg::ANG_W-1:0]          heading_angle,
    output logic                                overflow_flag
);

    drpi_pkg::pose_state_t state_reg;
    drpi_pkg::pose_state_t state_next;

    logic signed [drpi_pkg::POS_W-1:0]  start_x_reg;
    logic signed [drpi_pkg::POS_W-1:0]  start_y_reg;
    logic signed [drpi_pkg::POS_W-1:0]  x_reg;
    logic signed [drpi_pkg::POS_W-1:0]  y_reg;
    logic [drpi_pkg::ANG_W-1:0]         heading_reg;
    logic                               sat_reg;

    logic [1:0]                         unit_reg;
    logic                               neg_reg;
    logic [drpi_pkg::MAG_W-1:0]         mabs_reg;
    logic [drpi_pkg::DIST_W-1:0]        dist_reg;
    logic [drpi_pkg::PROD_W-1:0]        prod_reg;
    logic [drpi_pkg::PLO_W-1:0]         lo_reg;
    logic [drpi_pkg::INCR_W-1:0]        incr_reg;
    logic [drpi_pkg::QA_W-1:0]          qa_reg;
    logic [drpi_pkg::REM_W-1:0]         rem_reg;

    logic                               out_valid_reg;
    logic signed [drpi_pkg::POS_W-1:0]  pos_x_reg;
    logic signed [drpi_pkg::POS_W-1:0]  pos_y_reg;
    logic [drpi_pkg::ANG_W-1:0]         heading_out_reg;
    logic                               overflow_out_reg;

    logic                               capture;
    logic                               cordic_start;
    logic                               out_load;
    logic                               out_free;
    logic                               cordic_done;
    drpi_pkg::trig_t                    trig;

    logic [31:0]                        mul_a;
    logic [31:0]                        mul_b;
    logic [drpi_pkg::PROD_W-1:0]        prod_next;
    logic [drpi_pkg::DIST_W-1:0]        dist_next;
    logic [drpi_pkg::WIDE_W-1:0]        wide_sum;
    logic [drpi_pkg::INCR_W-1:0]        res_mag;
    logic                               res_neg;
    logic [drpi_pkg::INCR_W-1:0]        incr_next;
    logic signed [drpi_pkg::POS_W-1:0]  sat_base;
    logic [drpi_pkg::POS_W:0]           pos_sum;
    logic                               sat_hi;
    logic                               sat_lo;
    logic signed [drpi_pkg::POS_W-1:0]  pos_next;
    logic [drpi_pkg::PROD_W-1:0]        rad_prod;
    logic [drpi_pkg::PROD_W-1:0]        rad_sum;
    logic [drpi_pkg::ANG_W-1:0]         deg_q;
    logic [drpi_pkg::ANG_W-1:0]         deg_delta;
    logic [31:0]                        qa_wide;
    logic [31:0]                        qa_times45;
    logic [31:0]                        rem_wide;

    drpi_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (heading_reg),
        .done  (cordic_done),
        .trig  (trig)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drpi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        drpi_pkg::ACT_ADVANCE: state_next = drpi_pkg::ST_ADV_MUL;
                        drpi_pkg::ACT_TURN:    state_next = drpi_pkg::ST_TURN_MUL;
                        drpi_pkg::ACT_RESTART: state_next = drpi_pkg::ST_RESTART;
                        default:               state_next = drpi_pkg::ST_REPORT;
                    endcase
                end
            end
            drpi_pkg::ST_ADV_MUL:   state_next = drpi_pkg::ST_ADV_DIST;
            drpi_pkg::ST_ADV_DIST:  state_next = drpi_pkg::ST_TRIG_WAIT;
            drpi_pkg::ST_TRIG_WAIT:
            begin
                if (cordic_done)
                begin
                    state_next = drpi_pkg::ST_MXL;
                end
            end
            drpi_pkg::ST_MXL:       state_next = drpi_pkg::ST_MXH;
            drpi_pkg::ST_MXH:       state_next = drpi_pkg::ST_MYL;
            drpi_pkg::ST_MYL:       state_next = drpi_pkg::ST_MYH;
            drpi_pkg::ST_MYH:       state_next = drpi_pkg::ST_SUMY;
            drpi_pkg::ST_SUMY:      state_next = drpi_pkg::ST_ADDY;
            drpi_pkg::ST_ADDY:      state_next = drpi_pkg::ST_REPORT;
            drpi_pkg::ST_TURN_MUL:
            begin
                if (unit_reg == drpi_pkg::UNIT_RAD)
                begin
                    state_next = drpi_pkg::ST_RAD_ADD;
                end
                else
                begin
                    state_next = drpi_pkg::ST_DEG_Q;
                end
            end
            drpi_pkg::ST_RAD_ADD:   state_next = drpi_pkg::ST_REPORT;
            drpi_pkg::ST_DEG_Q:     state_next = drpi_pkg::ST_DEG_R;
            drpi_pkg::ST_DEG_R:     state_next = drpi_pkg::ST_DEG_MUL;
            drpi_pkg::ST_DEG_MUL:   state_next = drpi_pkg::ST_DEG_ADD;
            drpi_pkg::ST_DEG_ADD:   state_next = drpi_pkg::ST_REPORT;
            drpi_pkg::ST_RESTART:   state_next = drpi_pkg::ST_REPORT;
            drpi_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = drpi_pkg::ST_IDLE;
                end
            end
            default:                state_next = drpi_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall     = 1'b1;
        capture      = 1'b0;
        cordic_start = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            drpi_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                capture      = in_valid;
                cordic_start = in_valid && (action == drpi_pkg::ACT_ADVANCE);
            end
            drpi_pkg::ST_REPORT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = mabs_reg;
        mul_b = 32'd1;
        case (state_reg)
            drpi_pkg::ST_ADV_MUL:
            begin
                case (unit_reg)
                    drpi_pkg::UNIT_CM:
                    begin
                        mul_a = mabs_reg + drpi_pkg::CM_BIAS;
                        mul_b = drpi_pkg::RECIP_100;
                    end
                    drpi_pkg::UNIT_DM:
                    begin
                        mul_a = mabs_reg + drpi_pkg::DM_BIAS;
                        mul_b = drpi_pkg::RECIP_10;
                    end
                    drpi_pkg::UNIT_KM:
                    begin
                        mul_b = drpi_pkg::KM_SCALE;
                    end
                    default:
                    begin
                        mul_b = 32'd1;
                    end
                endcase
            end
            drpi_pkg::ST_MXL:
            begin
                mul_a = 32'(dist_reg[drpi_pkg::LO_W-1:0]);
                mul_b = trig.cos_mag;
            end
            drpi_pkg::ST_MXH:
            begin
                mul_a = 32'(dist_reg[drpi_pkg::DIST_W-1:drpi_pkg::LO_W]);
                mul_b = trig.cos_mag;
            end
            drpi_pkg::ST_MYL:
            begin
                mul_a = 32'(dist_reg[drpi_pkg::LO_W-1:0]);
                mul_b = trig.sin_mag;
            end
            drpi_pkg::ST_MYH:
            begin
                mul_a = 32'(dist_reg[drpi_pkg::DIST_W-1:drpi_pkg::LO_W]);
                mul_b = trig.sin_mag;
            end
            drpi_pkg::ST_TURN_MUL:
            begin
                mul_b = (unit_reg == drpi_pkg::UNIT_RAD) ? drpi_pkg::RAD_TO_BAM
                                                         : drpi_pkg::RECIP_45;
            end
            drpi_pkg::ST_DEG_MUL:
            begin
                mul_a = 32'({rem_reg, 13'd0}) + drpi_pkg::DEG_BIAS;
                mul_b = drpi_pkg::RECIP_45;
            end
            default:
            begin
                mul_b = 32'd1;
            end
        endcase
    end

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    // distance in meters from the conversion product, or the magnitude itself for meters
    always_comb
    begin
        case (unit_reg)
            drpi_pkg::UNIT_CM: dist_next = drpi_pkg::DIST_W'(prod_reg >> drpi_pkg::SHIFT_100);
            drpi_pkg::UNIT_DM: dist_next = drpi_pkg::DIST_W'(prod_reg >> drpi_pkg::SHIFT_10);
            drpi_pkg::UNIT_M:  dist_next = drpi_pkg::DIST_W'(mabs_reg);
            default:           dist_next = prod_reg[drpi_pkg::DIST_W-1:0];
        endcase
    end

    // q30 product, round half away from zero
    assign wide_sum  = {prod_reg[drpi_pkg::PHI_W-1:0], {drpi_pkg::LO_W{1'b0}}}
                     + drpi_pkg::WIDE_W'(lo_reg)
                     + (drpi_pkg::WIDE_W'(1) << 29);
    assign res_mag   = {1'b0, wide_sum[drpi_pkg::WIDE_W-1:30]};
    assign res_neg   = neg_reg ^ ((state_reg == drpi_pkg::ST_MYL) ? trig.cos_neg
                                                                  : trig.sin_neg);
    assign incr_next = res_neg ? (drpi_pkg::INCR_W'(0) - res_mag) : res_mag;

    // saturating position add
    assign sat_base = (state_reg == drpi_pkg::ST_MYH) ? x_reg : y_reg;
    assign pos_sum  = {sat_base[drpi_pkg::POS_W-1], sat_base}
                    + {{(drpi_pkg::POS_W + 1 - drpi_pkg::INCR_W){incr_reg[drpi_pkg::INCR_W-1]}},
                       incr_reg};
    assign sat_hi   = !pos_sum[drpi_pkg::POS_W] && pos_sum[drpi_pkg::POS_W-1];
    assign sat_lo   = pos_sum[drpi_pkg::POS_W] && !pos_sum[drpi_pkg::POS_W-1];
    assign pos_next = sat_hi ? drpi_pkg::POS_MAX
                    : (sat_lo ? drpi_pkg::POS_MIN : $signed(pos_sum[drpi_pkg::POS_W-1:0]));

    // turn conversions
    assign rad_prod   = neg_reg ? (drpi_pkg::PROD_W'(0) - prod_reg) : prod_reg;
    assign rad_sum    = rad_prod + drpi_pkg::PROD_W'(32'h8000);
    assign qa_wide    = 32'(qa_reg);
    assign qa_times45 = (qa_wide << 5) + (qa_wide << 3) + (qa_wide << 2) + qa_wide;
    assign rem_wide   = mabs_reg - qa_times45;
    assign deg_q      = {qa_reg[drpi_pkg::ANG_W-drpi_pkg::Q2_W-1:0],
                         drpi_pkg::Q2_W'(prod_reg >> drpi_pkg::SHIFT_45)};
    assign deg_delta  = neg_reg ? (drpi_pkg::ANG_W'(0) - deg_q) : deg_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drpi_pkg::ST_IDLE;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    drpi_pkg::REG_START_X: start_x_reg <= $signed(cfg_data);
                    drpi_pkg::REG_START_Y: start_y_reg <= $signed(cfg_data);
                    default:               start_x_reg <= start_x_reg;
                endcase
            end
            case (state_reg)
                drpi_pkg::ST_MYH:
                begin
                    x_reg   <= pos_next;
                    sat_reg <= sat_reg | sat_hi | sat_lo;
                end
                drpi_pkg::ST_ADDY:
                begin
                    y_reg   <= pos_next;
                    sat_reg <= sat_reg | sat_hi | sat_lo;
                end
                drpi_pkg::ST_RAD_ADD:
                begin
                    heading_reg <= heading_reg + rad_sum[47:16];
                end
                drpi_pkg::ST_DEG_ADD:
                begin
                    heading_reg <= heading_reg + deg_delta;
                end
                drpi_pkg::ST_RESTART:
                begin
                    x_reg       <= start_x_reg;
                    y_reg       <= start_y_reg;
                    heading_reg <= '0;
                    sat_reg     <= 1'b0;
                end
                default:
                begin
                    sat_reg <= sat_reg;
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (capture)
        begin
            unit_reg   <= unit;
            neg_reg    <= magnitude[drpi_pkg::MAG_W-1];
            mabs_reg   <= magnitude[drpi_pkg::MAG_W-1] ? (32'd0 - $unsigned(magnitude))
                                                       : $unsigned(magnitude);
        end
        case (state_reg)
            drpi_pkg::ST_ADV_DIST: dist_reg <= dist_next;
            drpi_pkg::ST_MXH:      lo_reg   <= prod_reg[drpi_pkg::PLO_W-1:0];
            drpi_pkg::ST_MYL:      incr_reg <= incr_next;
            drpi_pkg::ST_MYH:      lo_reg   <= prod_reg[drpi_pkg::PLO_W-1:0];
            drpi_pkg::ST_SUMY:     incr_reg <= incr_next;
            drpi_pkg::ST_DEG_Q:    qa_reg   <= drpi_pkg::QA_W'(prod_reg >> drpi_pkg::SHIFT_45);
            drpi_pkg::ST_DEG_R:    rem_reg  <= rem_wide[drpi_pkg::REM_W-1:0];
            default:               lo_reg   <= lo_reg;
        endcase
        if (out_load)
        begin
            pos_x_reg        <= x_reg;
            pos_y_reg        <= y_reg;
            heading_out_reg  <= heading_reg;
            overflow_out_reg <= sat_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign heading_angle = heading_out_reg;
    assign overflow_flag = overflow_out_reg;

    a_trig_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drpi_pkg::ST_MXL |-> cordic_done)
        else $error("position product started before cordic finished");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drpi_pkg::ST_DEG_MUL |-> rem_reg < 6'd45)
        else $error("degree conversion remainder out of range");

    a_sat_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sat_reg) |-> $past(state_reg == drpi_pkg::ST_MYH
                                 || state_reg == drpi_pkg::ST_ADDY))
        else $error("overflow flag set outside a position update");

    a_heading_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(heading_reg) |-> $past(state_reg == drpi_pkg::ST_RAD_ADD
                                        || state_reg == drpi_pkg::ST_DEG_ADD
                                        || state_reg == drpi_pkg::ST_RESTART))
        else $error("heading changed outside a turn or restart");

endmodule

[verif/dead_reckoning_pose_integrator_tb.sv]
// dead_reckoning_pose_integrator_tb: self-checking bench for the pose integrator,
// with a clocked command driver, a result monitor and a bit-exact pose predictor
// depends on drpi_pkg and dead_reckoning_pose_integrator
`timescale 1ns / 1ps

module dead_reckoning_pose_integrator_tb;

    import drpi_pkg::*;

    localparam logic [1:0] ACT_HOLD = 2'd3;
    localparam logic [1:0] UNIT_DEG = 2'd0;
    localparam int         DEG90    = 90 * 65536;
    localparam int         PHASES   = 6;
    localparam int         PHASE_CMDS = 305;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] amount;
        logic [1:0]         unit_code;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANG_W-1:0]        hdg;
        logic                    ovf;
    } pose_t;

    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_we        = 1'b0;
    logic                     cfg_index     = 1'b0;
    logic [POS_W-1:0]         cfg_data      = '0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic [1:0]               action        = ACT_ADVANCE;
    logic signed [MAG_W-1:0]  magnitude     = '0;
    logic [1:0]               unit          = UNIT_CM;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [ANG_W-1:0]         heading_angle;
    logic                     overflow_flag;

    dead_reckoning_pose_integrator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .magnitude     (magnitude),
        .unit          (unit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading_angle (heading_angle),
        .overflow_flag (overflow_flag)
    );

    cmd_t  cmd_queue[$];
    pose_t expected_poses[$];

    logic signed [POS_W-1:0] start_x_cfg = '0;
    logic signed [POS_W-1:0] start_y_cfg = '0;
    logic signed [POS_W-1:0] rover_x     = '0;
    logic signed [POS_W-1:0] rover_y     = '0;
    logic [ANG_W-1:0]        rover_heading = '0;
    logic                    rover_saturated = 1'b0;

    bit steady = 1'b0;
    int mismatches = 0;
    int n_advance = 0;
    int n_turn = 0;
    int n_restart = 0;
    int n_hold = 0;
    int n_clamp = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // pose predictor

    function automatic longint round_div(input longint v, input longint d);
        longint a;
        longint q;
        a = (v < 0) ? -v : v;
        q = (a + d / 2) / d;
        return (v < 0) ? -q : q;
    endfunction

    task automatic heading_trig(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] a;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        int          i;
        a = ang;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        // fold into [-90, 90) degrees, undo with a sign flip at the end
        if (flip)
            a = a - 32'h8000_0000;
        z = $signed(a);
        x = 64'sd652032874;
        y = 0;
        for (i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_STEP[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_STEP[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // distance times Q30 factor, rounded half away from zero
    function automatic longint scale_q30(input longint d, input longint q);
        bit           neg;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] p;
        neg = (d < 0) != (q < 0);
        a = (d < 0) ? -d : d;
        b = (q < 0) ? -q : q;
        p = (a * b + (128'd1 << 29)) >> 30;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_add(input logic signed [POS_W-1:0] p,
                                                         input longint d);
        longint v;
        v = longint'(p) + d;
        if (v > longint'(POS_MAX))
        begin
            rover_saturated = 1'b1;
            n_clamp++;
            return POS_MAX;
        end
        if (v < longint'(POS_MIN))
        begin
            rover_saturated = 1'b1;
            n_clamp++;
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    task automatic integrate_cmd(input cmd_t c);
        longint      meters;
        longint      cs;
        longint      sn;
        longint      q;
        logic [63:0] wide;
        case (c.op)
            ACT_ADVANCE:
            begin
                n_advance++;
                case (c.unit_code)
                    UNIT_CM: meters = round_div($signed(c.amount), 100);
                    UNIT_DM: meters = round_div($signed(c.amount), 10);
                    UNIT_M:  meters = $signed(c.amount);
                    default: meters = longint'($signed(c.amount)) * 1000;
                endcase
                heading_trig(rover_heading, cs, sn);
                rover_x = clamp_add(rover_x, scale_q30(meters, cs));
                rover_y = clamp_add(rover_y, scale_q30(meters, sn));
            end
            ACT_TURN:
            begin
                n_turn++;
                if (c.unit_code == UNIT_RAD)
                begin
                    wide = longint'($signed(c.amount)) * 64'sd683565276 + 64'sd32768;
                    rover_heading = rover_heading + wide[47:16];
                end
                else
                begin
                    // units 0, 2 and 3 read as degrees
                    q = round_div(longint'($signed(c.amount)) * 8192, 45);
                    wide = q;
                    rover_heading = rover_heading + wide[31:0];
                end
            end
            ACT_RESTART:
            begin
                n_restart++;
                rover_x = start_x_cfg;
                rover_y = start_y_cfg;
                rover_heading = '0;
                rover_saturated = 1'b0;
            end
            default:
                n_hold++;
        endcase
        expected_poses.push_back('{rover_x, rover_y, rover_heading, rover_saturated});
    endtask

    // command driver

    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        cmd_t head_cmd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                integrate_cmd('{action, magnitude, unit});
            if (!in_valid || !in_stall)
            begin
                if (cmd_queue.size() != 0 && (steady || $urandom_range(99) >= 28))
                begin
                    head_cmd = cmd_queue.pop_front();
                    in_valid  <= 1'b1;
                    action    <= head_cmd.op;
                    magnitude <= head_cmd.amount;
                    unit      <= head_cmd.unit_code;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor

    task automatic check_pose();
        pose_t want;
        bit    bad;
        if (expected_poses.size() == 0)
        begin
            mismatches++;
            $display("%0t: result transfer with no command pending, got x %h y %h", $time,
                     pos_x, pos_y);
            return;
        end
        want = expected_poses.pop_front();
        bad = 1'b0;
        if (pos_x !== want.x)
        begin
            bad = 1'b1;
            $display("%0t: pos_x expected %h got %h", $time, want.x, pos_x);
        end
        if (pos_y !== want.y)
        begin
            bad = 1'b1;
            $display("%0t: pos_y expected %h got %h", $time, want.y, pos_y);
        end
        if (heading_angle !== want.hdg)
        begin
            bad = 1'b1;
            $display("%0t: heading_angle expected %h got %h", $time, want.hdg, heading_angle);
        end
        if (overflow_flag !== want.ovf)
        begin
            bad = 1'b1;
            $display("%0t: overflow_flag expected %b got %b", $time, want.ovf, overflow_flag);
        end
        if (bad)
            mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_pose();
            out_stall <= !steady && ($urandom_range(99) < 28);
        end
    end

    // stimulus

    task automatic queue_cmd(input logic [1:0] op, input logic [31:0] amount,
                             input logic [1:0] unit_code);
        cmd_queue.push_back('{op, amount, unit_code});
    endtask

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 48)
            c.op = ACT_ADVANCE;
        else if (pick < 86)
            c.op = ACT_TURN;
        else if (pick < 94)
            c.op = ACT_RESTART;
        else
            c.op = ACT_HOLD;
        c.unit_code = 2'($urandom_range(3));
        case ($urandom_range(9))
            0, 1, 2, 3: c.amount = $urandom;
            4, 5, 6:
            begin
                c.amount = $urandom_range(1 << 20);
                if ($urandom_range(1))
                    c.amount = -c.amount;
            end
            7:
            begin
                case ($urandom_range(4))
                    0: c.amount = 32'h7FFF_FFFF;
                    1: c.amount = 32'h8000_0000;
                    2: c.amount = 32'h0000_0000;
                    3: c.amount = 32'h0000_0001;
                    default: c.amount = 32'hFFFF_FFFF;
                endcase
            end
            // whole multiples of 45 degrees land on the octant boundaries
            default: c.amount = (int'($urandom_range(8)) - 4) * 45 * 65536;
        endcase
        return c;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || expected_poses.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_start(input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_X;
        cfg_data  <= sx;
        @(posedge clk);
        cfg_index <= REG_START_Y;
        cfg_data  <= sy;
        @(posedge clk);
        cfg_we <= 1'b0;
        start_x_cfg = sx;
        start_y_cfg = sy;
    endtask

    initial
    begin : stimulus
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        int               p;
        int               n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of distance and units, heading around all four quadrants
        queue_cmd(ACT_ADVANCE, 32'h0001_0000, UNIT_M);
        queue_cmd(ACT_ADVANCE, 32'h7FFF_FFFF, UNIT_CM);
        queue_cmd(ACT_ADVANCE, 32'h8000_0000, UNIT_DM);
        queue_cmd(ACT_ADVANCE, 32'h7FFF_FFFF, UNIT_KM);
        queue_cmd(ACT_TURN, DEG90, UNIT_DEG);
        queue_cmd(ACT_ADVANCE, 32'h8000_0000, UNIT_KM);
        queue_cmd(ACT_TURN, DEG90, UNIT_DEG);
        queue_cmd(ACT_ADVANCE, 32'hFFFF_FFFF, UNIT_CM);
        queue_cmd(ACT_TURN, DEG90, UNIT_DEG);
        queue_cmd(ACT_ADVANCE, 32'h0001_0000, UNIT_M);
        queue_cmd(ACT_TURN, DEG90, UNIT_DEG);
        queue_cmd(ACT_TURN, 32'h7FFF_FFFF, UNIT_RAD);
        queue_cmd(ACT_TURN, 32'h8000_0000, UNIT_RAD);
        queue_cmd(ACT_TURN, 32'h7FFF_FFFF, UNIT_M);
        queue_cmd(ACT_TURN, 32'h8000_0000, UNIT_KM);
        queue_cmd(ACT_HOLD, 32'h5A5A_A5A5, UNIT_KM);
        queue_cmd(ACT_ADVANCE, 32'h7FFF_FFFF, UNIT_KM);
        queue_cmd(ACT_RESTART, 32'h0000_0000, UNIT_CM);
        wait_drained();

        // start at the corners so both axes clamp
        set_start(POS_MAX, POS_MIN);
        queue_cmd(ACT_RESTART, 32'hFFFF_FFFF, UNIT_KM);
        queue_cmd(ACT_ADVANCE, 32'h7FFF_FFFF, UNIT_KM);
        queue_cmd(ACT_TURN, -DEG90, UNIT_DEG);
        queue_cmd(ACT_ADVANCE, 32'h7FFF_FFFF, UNIT_KM);
        queue_cmd(ACT_HOLD, 32'h0000_0000, UNIT_CM);
        queue_cmd(ACT_RESTART, 32'h0000_0000, UNIT_M);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    sx = '0;
                    sy = '0;
                end
                1:
                begin
                    sx = POS_MIN;
                    sy = POS_MAX;
                end
                3:
                begin
                    sx = {{16{$urandom_range(1) == 1}}, 32'($urandom)};
                    sy = {{16{$urandom_range(1) == 1}}, 32'($urandom)};
                end
                4:
                begin
                    sx = POS_MAX - {16'd0, 32'($urandom)};
                    sy = POS_MIN + {16'd0, 32'($urandom)};
                end
                default:
                begin
                    sx = POS_W'({$urandom, $urandom});
                    sy = POS_W'({$urandom, $urandom});
                end
            endcase
            set_start(sx, sy);
            steady = (p == 2);
            for (n = 0; n < PHASE_CMDS; n++)
                cmd_queue.push_back(random_cmd());
            wait_drained();
            steady = 1'b0;
        end

        repeat (30) @(posedge clk);
        if (expected_poses.size() != 0)
        begin
            mismatches += expected_poses.size();
            $display("%0t: %0d expected results never arrived", $time, expected_poses.size());
        end
        $display("covered %0d advances, %0d turns, %0d restarts, %0d holds",
                 n_advance, n_turn, n_restart, n_hold);
        $display("position clamped %0d times over %0d start settings", n_clamp, PHASES + 2);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/drpi_pkg.sv
sv/drpi_cordic.sv
sv/dead_reckoning_pose_integrator.sv
verif/dead_reckoning_pose_integrator_tb.sv
